>>> src/i2p_pkg.sv
package i2p_pkg;

  // Operator stack size and derived widths
  localparam int STACK_DEPTH = 32;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Result buffer: one request yields at most one result per stack entry plus one
  localparam int OBUF_DEPTH  = STACK_DEPTH + 1;
  localparam int OBUF_AW     = $clog2(OBUF_DEPTH);
  localparam int OBUF_CW     = $clog2(OBUF_DEPTH + 1);

  // Microprogram counter width
  localparam int UPC_W       = 5;

  // Character codes
  localparam logic [7:0] CH_DIGIT_LO = 8'd49;   // '1'
  localparam logic [7:0] CH_DIGIT_HI = 8'd57;   // '9'
  localparam logic [7:0] CH_ALPHA_LO = 8'd97;   // 'a'
  localparam logic [7:0] CH_ALPHA_HI = 8'd122;  // 'z'
  localparam logic [7:0] CH_OPEN     = 8'h28;
  localparam logic [7:0] CH_CLOSE    = 8'h29;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_MUL      = 8'h2A;
  localparam logic [7:0] CH_DIV      = 8'h2F;
  localparam logic [7:0] CH_POW      = 8'h5E;
  localparam logic [7:0] CH_NUL      = 8'h00;

  // Stacked operator codes
  typedef logic [2:0] opc_t;
  localparam opc_t OP_OPEN  = 3'd0;
  localparam opc_t OP_PLUS  = 3'd1;
  localparam opc_t OP_MINUS = 3'd2;
  localparam opc_t OP_MUL   = 3'd3;
  localparam opc_t OP_DIV   = 3'd4;
  localparam opc_t OP_POW   = 3'd5;

  // Error codes
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_CLOSE    = 2'd1;
  localparam err_t ERR_OVERFLOW = 2'd2;
  localparam err_t ERR_OPEN     = 2'd3;

  // Channel payloads
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_expr;
  } in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       run_end;
    err_t       error_code;
  } out_t;

  // Jump conditions of the microprogram
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NOREQ,
    C_OPND,
    C_OP,
    C_CLOSE,
    C_LAST,
    C_EMPTY,
    C_POPOK,
    C_TOPOPEN,
    C_FULL,
    C_NRES0,
    C_RDONE,
    C_OBUSY
  } cond_t;

  // Datapath actions of one control word
  typedef struct packed {
    logic accept;
    logic rd_top;
    logic pop;
    logic push;
    logic emit_chr;
    logic emit_top;
    logic emit_null;
    logic flag_en;
    err_t flag_code;
    logic rd_buf;
    logic load_out;
    logic end_clear;
  } act_t;

  typedef struct packed {
    cond_t            cond;
    logic             inv;
    logic             gate;    // actions only when the jump is not taken
    logic [UPC_W-1:0] target;
    act_t             act;
  } uword_t;

  // Datapath status fed back to the sequencer
  typedef struct packed {
    logic noreq;
    logic opnd;
    logic op;
    logic close;
    logic last;
    logic empty;
    logic popok;
    logic topopen;
    logic full;
    logic nres0;
    logic rdone;
    logic obusy;
  } stat_t;

  function automatic logic is_operand(logic [7:0] c);
    return ((c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI)) ||
           ((c >= CH_ALPHA_LO) && (c <= CH_ALPHA_HI));
  endfunction

  function automatic logic is_operator(logic [7:0] c);
    return (c == CH_OPEN) || (c == CH_PLUS) || (c == CH_MINUS) ||
           (c == CH_MUL) || (c == CH_DIV) || (c == CH_POW);
  endfunction

  function automatic opc_t op_code(logic [7:0] c);
    opc_t r;
    case (c)
      CH_PLUS:  r = OP_PLUS;
      CH_MINUS: r = OP_MINUS;
      CH_MUL:   r = OP_MUL;
      CH_DIV:   r = OP_DIV;
      CH_POW:   r = OP_POW;
      default:  r = OP_OPEN;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(opc_t code);
    logic [7:0] r;
    case (code)
      OP_OPEN:  r = CH_OPEN;
      OP_PLUS:  r = CH_PLUS;
      OP_MINUS: r = CH_MINUS;
      OP_MUL:   r = CH_MUL;
      OP_DIV:   r = CH_DIV;
      OP_POW:   r = CH_POW;
      default:  r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] prio_incoming(opc_t code);
    logic [2:0] r;
    case (code)
      OP_OPEN:  r = 3'd5;
      OP_PLUS:  r = 3'd1;
      OP_MINUS: r = 3'd1;
      OP_MUL:   r = 3'd2;
      OP_DIV:   r = 3'd2;
      OP_POW:   r = 3'd4;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] prio_stacked(opc_t code);
    logic [2:0] r;
    case (code)
      OP_OPEN:  r = 3'd0;
      OP_PLUS:  r = 3'd1;
      OP_MINUS: r = 3'd1;
      OP_MUL:   r = 3'd2;
      OP_DIV:   r = 3'd2;
      OP_POW:   r = 3'd3;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/i2p_seq.sv
module i2p_seq (
  input  logic           clk,
  input  logic           rst,
  input  i2p_pkg::stat_t stat,
  output i2p_pkg::act_t  act,
  output logic           fetch_slot
);

  // Program labels
  localparam logic [i2p_pkg::UPC_W-1:0] S_FETCH = 5'd0;
  localparam logic [i2p_pkg::UPC_W-1:0] S_DSP1  = 5'd1;
  localparam logic [i2p_pkg::UPC_W-1:0] S_DSP2  = 5'd2;
  localparam logic [i2p_pkg::UPC_W-1:0] S_DSP3  = 5'd3;
  localparam logic [i2p_pkg::UPC_W-1:0] S_DSP4  = 5'd4;
  localparam logic [i2p_pkg::UPC_W-1:0] S_OPND  = 5'd5;
  localparam logic [i2p_pkg::UPC_W-1:0] S_OP    = 5'd6;
  localparam logic [i2p_pkg::UPC_W-1:0] S_OPCMP = 5'd7;
  localparam logic [i2p_pkg::UPC_W-1:0] S_OPPOP = 5'd8;
  localparam logic [i2p_pkg::UPC_W-1:0] S_PUSH  = 5'd9;
  localparam logic [i2p_pkg::UPC_W-1:0] S_PUSHW = 5'd10;
  localparam logic [i2p_pkg::UPC_W-1:0] S_OVF   = 5'd11;
  localparam logic [i2p_pkg::UPC_W-1:0] S_CLS   = 5'd12;
  localparam logic [i2p_pkg::UPC_W-1:0] S_CLCMP = 5'd13;
  localparam logic [i2p_pkg::UPC_W-1:0] S_CLPOP = 5'd14;
  localparam logic [i2p_pkg::UPC_W-1:0] S_DROP  = 5'd15;
  localparam logic [i2p_pkg::UPC_W-1:0] S_UNM   = 5'd16;
  localparam logic [i2p_pkg::UPC_W-1:0] S_END   = 5'd17;
  localparam logic [i2p_pkg::UPC_W-1:0] S_FLUSH = 5'd18;
  localparam logic [i2p_pkg::UPC_W-1:0] S_FLCMP = 5'd19;
  localparam logic [i2p_pkg::UPC_W-1:0] S_FLPOP = 5'd20;
  localparam logic [i2p_pkg::UPC_W-1:0] S_FOPEN = 5'd21;
  localparam logic [i2p_pkg::UPC_W-1:0] S_ENDE  = 5'd22;
  localparam logic [i2p_pkg::UPC_W-1:0] S_RPL   = 5'd23;
  localparam logic [i2p_pkg::UPC_W-1:0] S_LOAD  = 5'd24;
  localparam logic [i2p_pkg::UPC_W-1:0] S_LOOP  = 5'd25;
  localparam logic [i2p_pkg::UPC_W-1:0] S_FIN   = 5'd26;
  localparam logic [i2p_pkg::UPC_W-1:0] S_DONE  = 5'd27;

  logic [i2p_pkg::UPC_W-1:0] upc;
  logic [i2p_pkg::UPC_W-1:0] upc_next;
  i2p_pkg::uword_t           w;
  logic                      cond_hit;
  logic                      take;

  // Control store
  always_comb begin
    w        = '0;
    w.cond   = i2p_pkg::C_ALWAYS;
    w.inv    = 1'b1;
    w.target = S_FETCH;
    unique case (upc)
      S_FETCH: begin
        w.cond = i2p_pkg::C_NOREQ; w.inv = 1'b0; w.gate = 1'b1; w.target = S_FETCH;
        w.act.accept = 1'b1;
      end
      S_DSP1: begin w.cond = i2p_pkg::C_OPND;  w.inv = 1'b0; w.target = S_OPND; end
      S_DSP2: begin w.cond = i2p_pkg::C_OP;    w.inv = 1'b0; w.target = S_OP;   end
      S_DSP3: begin w.cond = i2p_pkg::C_CLOSE; w.inv = 1'b0; w.target = S_CLS;  end
      S_DSP4: begin w.inv = 1'b0; w.target = S_END; end
      S_OPND: begin
        w.inv = 1'b0; w.target = S_END;
        w.act.emit_chr = 1'b1;
      end
      // operator: pop while stacked priority >= incoming priority
      S_OP: begin
        w.cond = i2p_pkg::C_EMPTY; w.inv = 1'b0; w.gate = 1'b1; w.target = S_PUSH;
        w.act.rd_top = 1'b1;
      end
      S_OPCMP: begin w.cond = i2p_pkg::C_POPOK; w.inv = 1'b1; w.target = S_PUSH; end
      S_OPPOP: begin
        w.inv = 1'b0; w.target = S_OP;
        w.act.emit_top = 1'b1; w.act.pop = 1'b1;
      end
      S_PUSH:  begin w.cond = i2p_pkg::C_FULL; w.inv = 1'b0; w.target = S_OVF; end
      S_PUSHW: begin
        w.inv = 1'b0; w.target = S_END;
        w.act.push = 1'b1;
      end
      S_OVF: begin
        w.inv = 1'b0; w.target = S_END;
        w.act.flag_en = 1'b1; w.act.flag_code = i2p_pkg::ERR_OVERFLOW;
      end
      // close: pop down to the matching open
      S_CLS: begin
        w.cond = i2p_pkg::C_EMPTY; w.inv = 1'b0; w.gate = 1'b1; w.target = S_UNM;
        w.act.rd_top = 1'b1;
      end
      S_CLCMP: begin w.cond = i2p_pkg::C_TOPOPEN; w.inv = 1'b0; w.target = S_DROP; end
      S_CLPOP: begin
        w.inv = 1'b0; w.target = S_CLS;
        w.act.emit_top = 1'b1; w.act.pop = 1'b1;
      end
      S_DROP: begin
        w.inv = 1'b0; w.target = S_END;
        w.act.pop = 1'b1;
      end
      S_UNM: begin
        w.act.flag_en = 1'b1; w.act.flag_code = i2p_pkg::ERR_CLOSE;
      end
      // end of request: flush the stack when the last character is in
      S_END:   begin w.cond = i2p_pkg::C_LAST; w.inv = 1'b1; w.target = S_RPL; end
      S_FLUSH: begin
        w.cond = i2p_pkg::C_EMPTY; w.inv = 1'b0; w.gate = 1'b1; w.target = S_ENDE;
        w.act.rd_top = 1'b1;
      end
      S_FLCMP: begin w.cond = i2p_pkg::C_TOPOPEN; w.inv = 1'b0; w.target = S_FOPEN; end
      S_FLPOP: begin
        w.inv = 1'b0; w.target = S_FLUSH;
        w.act.emit_top = 1'b1; w.act.pop = 1'b1;
      end
      S_FOPEN: begin
        w.inv = 1'b0; w.target = S_FLUSH;
        w.act.pop = 1'b1;
        w.act.flag_en = 1'b1; w.act.flag_code = i2p_pkg::ERR_OPEN;
      end
      S_ENDE: begin
        w.cond = i2p_pkg::C_NRES0; w.inv = 1'b1; w.gate = 1'b1; w.target = S_RPL;
        w.act.emit_null = 1'b1;
      end
      // replay buffered results with the final error code
      S_RPL: begin
        w.cond = i2p_pkg::C_RDONE; w.inv = 1'b0; w.gate = 1'b1; w.target = S_FIN;
        w.act.rd_buf = 1'b1;
      end
      S_LOAD: begin
        w.cond = i2p_pkg::C_OBUSY; w.inv = 1'b0; w.gate = 1'b1; w.target = S_LOAD;
        w.act.load_out = 1'b1;
      end
      S_LOOP: begin w.inv = 1'b0; w.target = S_RPL; end
      S_FIN: begin
        w.cond = i2p_pkg::C_LAST; w.inv = 1'b1; w.gate = 1'b1; w.target = S_FETCH;
        w.act.end_clear = 1'b1;
      end
      S_DONE: begin w.inv = 1'b0; w.target = S_FETCH; end
      default: begin w.inv = 1'b0; w.target = S_FETCH; end
    endcase
  end

  // Condition select
  always_comb begin
    unique case (w.cond)
      i2p_pkg::C_ALWAYS:  cond_hit = 1'b1;
      i2p_pkg::C_NOREQ:   cond_hit = stat.noreq;
      i2p_pkg::C_OPND:    cond_hit = stat.opnd;
      i2p_pkg::C_OP:      cond_hit = stat.op;
      i2p_pkg::C_CLOSE:   cond_hit = stat.close;
      i2p_pkg::C_LAST:    cond_hit = stat.last;
      i2p_pkg::C_EMPTY:   cond_hit = stat.empty;
      i2p_pkg::C_POPOK:   cond_hit = stat.popok;
      i2p_pkg::C_TOPOPEN: cond_hit = stat.topopen;
      i2p_pkg::C_FULL:    cond_hit = stat.full;
      i2p_pkg::C_NRES0:   cond_hit = stat.nres0;
      i2p_pkg::C_RDONE:   cond_hit = stat.rdone;
      i2p_pkg::C_OBUSY:   cond_hit = stat.obusy;
      default:            cond_hit = 1'b0;
    endcase
  end

  assign take       = cond_hit ^ w.inv;
  assign act        = (w.gate && take) ? '0 : w.act;
  assign fetch_slot = w.act.accept;
  assign upc_next   = take ? w.target : upc + 1'b1;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

>>> src/i2p_datapath.sv
module i2p_datapath (
  input  logic           clk,
  input  logic           rst,
  input  i2p_pkg::act_t  act,
  input  logic           char_valid,
  input  i2p_pkg::in_t   char_req,
  input  logic           sym_stall,
  output i2p_pkg::stat_t stat,
  output logic           sym_valid,
  output i2p_pkg::out_t  sym_req
);

  logic [7:0]                 chr;
  logic                       last;
  logic [i2p_pkg::CNT_W-1:0]  cnt;
  logic [i2p_pkg::CNT_W-1:0]  cnt_m1;
  i2p_pkg::err_t              err;
  i2p_pkg::opc_t              top;
  i2p_pkg::opc_t              opc;
  logic [i2p_pkg::OBUF_CW-1:0] nres;
  logic [i2p_pkg::OBUF_CW-1:0] rptr;
  logic [8:0]                 buf_rd;
  logic [8:0]                 buf_wd;
  logic                       buf_we;

  i2p_pkg::opc_t stack_mem [i2p_pkg::STACK_DEPTH];
  logic [8:0]    obuf_mem  [i2p_pkg::OBUF_DEPTH];

  assign opc    = i2p_pkg::op_code(chr);
  assign cnt_m1 = cnt - 1'b1;

  // Status to the sequencer
  always_comb begin
    stat.noreq   = !char_valid;
    stat.opnd    = i2p_pkg::is_operand(chr);
    stat.op      = i2p_pkg::is_operator(chr);
    stat.close   = (chr == i2p_pkg::CH_CLOSE);
    stat.last    = last;
    stat.empty   = (cnt == '0);
    stat.popok   = (i2p_pkg::prio_stacked(top) >= i2p_pkg::prio_incoming(opc));
    stat.topopen = (top == i2p_pkg::OP_OPEN);
    stat.full    = (cnt == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
    stat.nres0   = (nres == '0);
    stat.rdone   = (rptr == nres);
    stat.obusy   = sym_valid && sym_stall;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (act.accept) begin
      chr  <= char_req.char_in;
      last <= char_req.end_of_expr;
    end
  end

  // Operator stack: write on push, registered top read
  always_ff @(posedge clk) begin
    if (act.push) begin
      stack_mem[cnt[i2p_pkg::STACK_AW-1:0]] <= opc;
    end
    if (act.rd_top) begin
      top <= stack_mem[cnt_m1[i2p_pkg::STACK_AW-1:0]];
    end
  end

  // Stack count and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      err <= i2p_pkg::ERR_NONE;
    end else begin
      if (act.end_clear) begin
        cnt <= '0;
        err <= i2p_pkg::ERR_NONE;
      end else begin
        if (act.pop) begin
          cnt <= cnt_m1;
        end else if (act.push) begin
          cnt <= cnt + 1'b1;
        end
        if (act.flag_en && (err == i2p_pkg::ERR_NONE)) begin
          err <= act.flag_code;
        end
      end
    end
  end

  // Result buffer write data: {valid, symbol}
  always_comb begin
    buf_we = act.emit_chr || act.emit_top || act.emit_null;
    if (act.emit_chr) begin
      buf_wd = {1'b1, chr};
    end else if (act.emit_top) begin
      buf_wd = {1'b1, i2p_pkg::code_char(top)};
    end else begin
      buf_wd = {1'b0, i2p_pkg::CH_NUL};
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      obuf_mem[nres[i2p_pkg::OBUF_AW-1:0]] <= buf_wd;
    end
    if (act.rd_buf) begin
      buf_rd <= obuf_mem[rptr[i2p_pkg::OBUF_AW-1:0]];
    end
  end

  // Buffer fill and replay pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      nres <= '0;
      rptr <= '0;
    end else begin
      if (act.accept) begin
        nres <= '0;
        rptr <= '0;
      end else begin
        if (buf_we) begin
          nres <= nres + 1'b1;
        end
        if (act.rd_buf) begin
          rptr <= rptr + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (act.load_out) begin
      sym_valid <= 1'b1;
    end else if (!sym_stall) begin
      sym_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act.load_out) begin
      sym_req.symbol       <= buf_rd[7:0];
      sym_req.symbol_valid <= buf_rd[8];
      sym_req.run_end      <= last && (rptr == nres);
      sym_req.error_code   <= err;
    end
  end

endmodule

>>> src/infix_to_postfix_converter_unit.sv
// Channel   Direction  Handshake                 Payload
// char      in         char_valid / char_stall   char_req (i2p_pkg::in_t)
// sym       out        sym_valid  / sym_stall    sym_req  (i2p_pkg::out_t)
//
// One request at a time runs through a microprogram of 28 steps: the steps of its
// character class and end flush, plus a read, compare and pop pass per stack
// entry popped (registered stack read), and a buffer read, load and loop pass per result.
// Results of a request are buffered and replayed so all carry the final error.
// rst is synchronous; it clears the step counter, stack count, error, buffer pointers and valid.
// A stalled output holds the replay loop; char_stall is low only in the fetch step.
module infix_to_postfix_converter_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  output logic          char_stall,
  input  i2p_pkg::in_t  char_req,
  output logic          sym_valid,
  input  logic          sym_stall,
  output i2p_pkg::out_t sym_req
);

  i2p_pkg::act_t  act;
  i2p_pkg::stat_t stat;
  logic           fetch_slot;

  // Microcode sequencer
  i2p_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .stat       (stat),
    .act        (act),
    .fetch_slot (fetch_slot)
  );

  // Stack, result buffer and output register
  i2p_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .act        (act),
    .char_valid (char_valid),
    .char_req   (char_req),
    .sym_stall  (sym_stall),
    .stat       (stat),
    .sym_valid  (sym_valid),
    .sym_req    (sym_req)
  );

  assign char_stall = !fetch_slot;

endmodule
